// ===== hdl/slr_pkg.sv =====
// Shared types, codes and parse tables of the SLR expression parse engine.
package slr_pkg;

    // Port widths of the item fields
    localparam int unsigned TOKEN_W = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned PROD_W  = 3;
    localparam int unsigned STATE_W = 4;
    localparam int unsigned DEPTH_W = 6;

    // Parameter defaults
    localparam int unsigned DEF_STACK_DEPTH = 32;
    localparam int unsigned DEF_VALUE_WIDTH = 32;

    // Reductions allowed per token before the token is refused
    localparam int unsigned MAX_RED = 4;

    // Terminal code of a number token
    localparam logic [TOKEN_W-1:0] TOK_NUM = 3'd0;

    // High nibble of an action table entry
    localparam logic [3:0] TK_ERR    = 4'd0;
    localparam logic [3:0] TK_SHIFT  = 4'd1;
    localparam logic [3:0] TK_REDUCE = 4'd2;
    localparam logic [3:0] TK_ACCEPT = 4'd3;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        AK_REDUCE   = 3'd0,
        AK_SHIFT    = 3'd1,
        AK_ACCEPT   = 3'd2,
        AK_SYNTAX   = 3'd3,
        AK_OVERFLOW = 3'd4
    } t_akind;

    // Datapath operations selected by the microcode
    typedef enum logic [2:0] {
        UOP_LOAD,
        UOP_DISPATCH,
        UOP_REDUCE,
        UOP_SHIFT,
        UOP_ACCEPT,
        UOP_ERROR
    } t_uop;

    // Class of the action that the current token calls for
    typedef enum logic [1:0] {
        CLS_REDUCE,
        CLS_SHIFT,
        CLS_ACCEPT,
        CLS_ERROR
    } t_cls;

    // Sequencer to datapath
    typedef struct packed {
        logic take;
        logic fire;
        t_uop op;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        t_cls cls;
        logic goto_ok;
        logic out_free;
    } t_stat;

    // Action table: state by terminal
    localparam logic [7:0] ACT_TAB [0:15][0:7] = '{
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h00, 8'h16, 8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30},
        '{8'h00, 8'h22, 8'h22, 8'h18, 8'h19, 8'h00, 8'h22, 8'h22},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h00, 8'h26, 8'h26, 8'h26, 8'h26, 8'h00, 8'h26, 8'h26},
        '{8'h00, 8'h25, 8'h25, 8'h25, 8'h25, 8'h00, 8'h25, 8'h25},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h00, 8'h16, 8'h17, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h00},
        '{8'h00, 8'h20, 8'h20, 8'h18, 8'h19, 8'h00, 8'h20, 8'h20},
        '{8'h00, 8'h21, 8'h21, 8'h18, 8'h19, 8'h00, 8'h21, 8'h21},
        '{8'h00, 8'h23, 8'h23, 8'h23, 8'h23, 8'h00, 8'h23, 8'h23},
        '{8'h00, 8'h24, 8'h24, 8'h24, 8'h24, 8'h00, 8'h24, 8'h24},
        '{8'h00, 8'h27, 8'h27, 8'h27, 8'h27, 8'h00, 8'h27, 8'h27}
    };

    // Goto table on E, T, F; last column pads the 2-bit index, zero means no entry
    localparam logic [STATE_W-1:0] GOTO_TAB [0:15][0:3] = '{
        '{4'd1, 4'd2,  4'd5,  4'd0}, '{4'd0, 4'd0,  4'd0,  4'd0},
        '{4'd0, 4'd0,  4'd0,  4'd0}, '{4'd10, 4'd2, 4'd5,  4'd0},
        '{4'd0, 4'd0,  4'd0,  4'd0}, '{4'd0, 4'd0,  4'd0,  4'd0},
        '{4'd0, 4'd11, 4'd5,  4'd0}, '{4'd0, 4'd12, 4'd5,  4'd0},
        '{4'd0, 4'd0,  4'd13, 4'd0}, '{4'd0, 4'd0,  4'd14, 4'd0},
        '{4'd0, 4'd0,  4'd0,  4'd0}, '{4'd0, 4'd0,  4'd0,  4'd0},
        '{4'd0, 4'd0,  4'd0,  4'd0}, '{4'd0, 4'd0,  4'd0,  4'd0},
        '{4'd0, 4'd0,  4'd0,  4'd0}, '{4'd0, 4'd0,  4'd0,  4'd0}
    };

    // Left-hand nonterminal and right-hand length of each rule
    localparam logic [1:0] RULE_LHS [0:7] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [1:0] RULE_LEN [0:7] = '{2'd3, 2'd3, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1, 2'd3};

endpackage

// ===== hdl/slr_seq.sv =====
// Microcode sequencer: program counter, control store and jump logic.
module slr_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  slr_pkg::t_stat i_stat,
    output slr_pkg::t_ctrl o_ctrl
);

    // Jump conditions
    typedef enum logic [1:0] {
        JC_WAIT,
        JC_CLASS,
        JC_GOTO,
        JC_JUMP
    } t_jc;

    // Control word
    typedef struct packed {
        logic          take;
        logic          emit;
        slr_pkg::t_uop op;
        t_jc           jc;
        logic [2:0]    target;
    } t_uword;

    localparam logic [2:0] PC_FETCH  = 3'd0;
    localparam logic [2:0] PC_DISP   = 3'd1;
    localparam logic [2:0] PC_REDUCE = 3'd2;
    localparam logic [2:0] PC_SHIFT  = 3'd3;
    localparam logic [2:0] PC_ACCEPT = 3'd4;
    localparam logic [2:0] PC_ERROR  = 3'd5;

    // Control store
    function automatic t_uword ucode(input logic [2:0] pc);
        t_uword w;
        case (pc)
            PC_FETCH:  w = '{1'b1, 1'b0, slr_pkg::UOP_LOAD,     JC_WAIT,  PC_DISP};
            PC_DISP:   w = '{1'b0, 1'b0, slr_pkg::UOP_DISPATCH, JC_CLASS, PC_FETCH};
            PC_REDUCE: w = '{1'b0, 1'b1, slr_pkg::UOP_REDUCE,   JC_GOTO,  PC_DISP};
            PC_SHIFT:  w = '{1'b0, 1'b1, slr_pkg::UOP_SHIFT,    JC_JUMP,  PC_FETCH};
            PC_ACCEPT: w = '{1'b0, 1'b1, slr_pkg::UOP_ACCEPT,   JC_JUMP,  PC_FETCH};
            PC_ERROR:  w = '{1'b0, 1'b1, slr_pkg::UOP_ERROR,    JC_JUMP,  PC_FETCH};
            default:   w = '{1'b1, 1'b0, slr_pkg::UOP_LOAD,     JC_WAIT,  PC_DISP};
        endcase
        return w;
    endfunction

    logic [2:0] r_pc;
    logic [2:0] n_pc;
    t_uword     w;
    logic       fire;

    // Step enable: emitting steps wait for the output register, fetch waits for an item
    always_comb begin
        w    = ucode(r_pc);
        fire = !(w.emit && !i_stat.out_free) && (!w.take || i_in_valid);
        n_pc = r_pc;
        if (fire) begin
            case (w.jc)
                JC_WAIT:  n_pc = w.target;
                JC_CLASS: begin
                    case (i_stat.cls)
                        slr_pkg::CLS_REDUCE: n_pc = PC_REDUCE;
                        slr_pkg::CLS_SHIFT:  n_pc = PC_SHIFT;
                        slr_pkg::CLS_ACCEPT: n_pc = PC_ACCEPT;
                        default:             n_pc = PC_ERROR;
                    endcase
                end
                JC_GOTO:  n_pc = i_stat.goto_ok ? w.target : PC_FETCH;
                JC_JUMP:  n_pc = w.target;
                default:  n_pc = PC_FETCH;
            endcase
        end
        o_ctrl.take = w.take;
        o_ctrl.fire = fire;
        o_ctrl.op   = w.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== hdl/slr_dp.sv =====
// Parser datapath: token registers, state stack memory, table lookups and result register.
module slr_dp #(
    parameter int unsigned STACK_DEPTH = slr_pkg::DEF_STACK_DEPTH,
    parameter int unsigned VALUE_WIDTH = slr_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slr_pkg::t_ctrl                i_ctrl,
    input  logic [slr_pkg::TOKEN_W-1:0]   i_token_kind,
    input  logic [slr_pkg::VALUE_W-1:0]   i_token_value,
    input  logic                          i_out_stall,
    output slr_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [slr_pkg::KIND_W-1:0]    o_action_kind,
    output logic [slr_pkg::PROD_W-1:0]    o_production,
    output logic [slr_pkg::STATE_W-1:0]   o_new_state,
    output logic [slr_pkg::VALUE_W-1:0]   o_shifted_value,
    output logic [slr_pkg::DEPTH_W-1:0]   o_depth_after,
    output logic                          o_run_last
);

    localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW  = $clog2(STACK_DEPTH);
    localparam int unsigned OW  = slr_pkg::VALUE_W;
    localparam int unsigned VW  = (VALUE_WIDTH < OW) ? VALUE_WIDTH : OW;
    localparam int unsigned SW  = slr_pkg::STATE_W;
    localparam int unsigned DW  = slr_pkg::DEPTH_W;

    // State stack; entry 0 is never written and reads as state 0
    logic [SW-1:0] mem [0:STACK_DEPTH-1];
    logic [SW-1:0] r_rd;
    logic          r_rd_zero;
    logic          n_rd_zero;

    logic [SW-1:0]                 r_top, n_top;
    logic [SPW-1:0]                r_sp, n_sp;
    logic [slr_pkg::TOKEN_W-1:0]   r_tok, n_tok;
    logic [VW-1:0]                 r_val, n_val;
    logic [2:0]                    r_rcnt, n_rcnt;
    logic [slr_pkg::PROD_W-1:0]    r_prod, n_prod;
    logic [1:0]                    r_lhs, n_lhs;
    logic [SW-1:0]                 r_num, n_num;
    logic [SPW-1:0]                r_idx, n_idx;

    // Result register
    logic                          r_ov, n_ov;
    slr_pkg::t_akind               r_kind, e_kind;
    logic [slr_pkg::PROD_W-1:0]    r_oprod, e_prod;
    logic [SW-1:0]                 r_ostate, e_state;
    logic [OW-1:0]                 r_oval, e_val;
    logic [DW-1:0]                 r_odepth, e_depth;
    logic                          r_olast, e_last;
    logic                          load;

    logic [7:0]     act;
    logic [3:0]     akind;
    logic [3:0]     anum;
    logic [1:0]     rlen;
    logic [SPW-1:0] idx_new;
    logic [SW-1:0]  below;
    logic [SW-1:0]  goto_st;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [SW-1:0]  wdata;
    logic           re;
    logic [AW-1:0]  raddr;

    // Action decode for the top state and current token
    always_comb begin
        act     = slr_pkg::ACT_TAB[r_top][r_tok];
        akind   = act[7:4];
        anum    = act[3:0];
        rlen    = slr_pkg::RULE_LEN[anum[2:0]];
        idx_new = r_sp - SPW'(rlen);
        if (akind == slr_pkg::TK_REDUCE && r_rcnt < 3'(slr_pkg::MAX_RED)) begin
            o_stat.cls = (r_sp <= SPW'(rlen)) ? slr_pkg::CLS_ERROR : slr_pkg::CLS_REDUCE;
        end else if (akind == slr_pkg::TK_SHIFT) begin
            o_stat.cls = slr_pkg::CLS_SHIFT;
        end else if (akind == slr_pkg::TK_ACCEPT) begin
            o_stat.cls = slr_pkg::CLS_ACCEPT;
        end else begin
            o_stat.cls = slr_pkg::CLS_ERROR;
        end
        below          = r_rd_zero ? '0 : r_rd;
        goto_st        = slr_pkg::GOTO_TAB[below][r_lhs];
        o_stat.goto_ok = (goto_st != '0);
        o_stat.out_free = !r_ov || !i_out_stall;
    end

    // Step operations
    always_comb begin
        n_top     = r_top;
        n_sp      = r_sp;
        n_tok     = r_tok;
        n_val     = r_val;
        n_rcnt    = r_rcnt;
        n_prod    = r_prod;
        n_lhs     = r_lhs;
        n_num     = r_num;
        n_idx     = r_idx;
        n_rd_zero = r_rd_zero;
        we        = 1'b0;
        waddr     = AW'(r_idx);
        wdata     = goto_st;
        re        = 1'b0;
        raddr     = AW'(idx_new - SPW'(1));
        load      = 1'b0;
        e_kind    = slr_pkg::AK_SYNTAX;
        e_prod    = '0;
        e_state   = '0;
        e_val     = '0;
        e_depth   = DW'(1);
        e_last    = 1'b1;
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                slr_pkg::UOP_LOAD: begin
                    n_tok  = i_token_kind;
                    n_val  = i_token_value[VW-1:0];
                    n_rcnt = '0;
                end
                slr_pkg::UOP_DISPATCH: begin
                    n_prod    = anum[2:0];
                    n_lhs     = slr_pkg::RULE_LHS[anum[2:0]];
                    n_num     = anum;
                    n_idx     = idx_new;
                    n_rd_zero = (idx_new == SPW'(1));
                    re        = 1'b1;
                end
                slr_pkg::UOP_REDUCE: begin
                    load = 1'b1;
                    if (o_stat.goto_ok) begin
                        we      = 1'b1;
                        n_top   = goto_st;
                        n_sp    = r_idx + SPW'(1);
                        n_rcnt  = r_rcnt + 3'd1;
                        e_kind  = slr_pkg::AK_REDUCE;
                        e_prod  = r_prod;
                        e_state = goto_st;
                        e_depth = DW'(r_idx + SPW'(1));
                        e_last  = 1'b0;
                    end else begin
                        n_top = '0;
                        n_sp  = SPW'(1);
                    end
                end
                slr_pkg::UOP_SHIFT: begin
                    load = 1'b1;
                    if (r_sp == SPW'(STACK_DEPTH)) begin
                        // stack full: overflow and start over
                        n_top  = '0;
                        n_sp   = SPW'(1);
                        e_kind = slr_pkg::AK_OVERFLOW;
                    end else begin
                        we      = 1'b1;
                        waddr   = AW'(r_sp);
                        wdata   = r_num;
                        n_top   = r_num;
                        n_sp    = r_sp + SPW'(1);
                        e_kind  = slr_pkg::AK_SHIFT;
                        e_state = r_num;
                        e_val   = (r_tok == slr_pkg::TOK_NUM) ? OW'(r_val) : '0;
                        e_depth = DW'(r_sp + SPW'(1));
                    end
                end
                slr_pkg::UOP_ACCEPT: begin
                    load   = 1'b1;
                    n_top  = '0;
                    n_sp   = SPW'(1);
                    e_kind = slr_pkg::AK_ACCEPT;
                end
                slr_pkg::UOP_ERROR: begin
                    load  = 1'b1;
                    n_top = '0;
                    n_sp  = SPW'(1);
                end
                default: ;
            endcase
        end
        n_ov = load || (r_ov && i_out_stall);
    end

    // Stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= mem[raddr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_sp   <= SPW'(1);
            r_rcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_top  <= n_top;
            r_sp   <= n_sp;
            r_rcnt <= n_rcnt;
            r_ov   <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tok     <= n_tok;
        r_val     <= n_val;
        r_prod    <= n_prod;
        r_lhs     <= n_lhs;
        r_num     <= n_num;
        r_idx     <= n_idx;
        r_rd_zero <= n_rd_zero;
        if (load) begin
            r_kind   <= e_kind;
            r_oprod  <= e_prod;
            r_ostate <= e_state;
            r_oval   <= e_val;
            r_odepth <= e_depth;
            r_olast  <= e_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_action_kind   = r_kind;
    assign o_production    = r_oprod;
    assign o_new_state     = r_ostate;
    assign o_shifted_value = r_oval;
    assign o_depth_after   = r_odepth;
    assign o_run_last      = r_olast;

endmodule

// ===== hdl/slr_expression_parse_engine_top.sv =====
// Top level of the SLR shift-reduce expression parse engine.
//
// Input channel: one token per item (i_token_kind, i_token_value), taken at a
// clock edge where i_in_valid is high and o_in_stall is low. Output channel:
// one parse action per item (reduce, shift, accept, syntax error, overflow),
// presented while o_out_valid is high and taken when i_out_stall is low.
// Each token yields its reductions in order (0 to 3 from the table), then one
// shift, accept or error item; o_run_last marks the final item of the token.
// The microcode steps one control word a cycle while no step is held, and
// each reduction spends two steps for the registered read of the state below
// the popped rule. A taken token passes the dispatch step before its first
// result is registered. A stalled output holds the emitting step; the next
// token waits in fetch. Reset (i_rst_n low at a clock edge) leaves one stack
// entry holding state 0, the sequencer in fetch and no result pending; the
// stack memory is not swept.
module slr_expression_parse_engine_top #(
    parameter int unsigned STACK_DEPTH = slr_pkg::DEF_STACK_DEPTH,
    parameter int unsigned VALUE_WIDTH = slr_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [slr_pkg::TOKEN_W-1:0]   i_token_kind,
    input  logic [slr_pkg::VALUE_W-1:0]   i_token_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [slr_pkg::KIND_W-1:0]    o_action_kind,
    output logic [slr_pkg::PROD_W-1:0]    o_production,
    output logic [slr_pkg::STATE_W-1:0]   o_new_state,
    output logic [slr_pkg::VALUE_W-1:0]   o_shifted_value,
    output logic [slr_pkg::DEPTH_W-1:0]   o_depth_after,
    output logic                          o_run_last
);

    slr_pkg::t_ctrl ctrl;
    slr_pkg::t_stat stat;

    // Sequencer
    slr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // Datapath
    slr_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_token_kind    (i_token_kind),
        .i_token_value   (i_token_value),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_action_kind   (o_action_kind),
        .o_production    (o_production),
        .o_new_state     (o_new_state),
        .o_shifted_value (o_shifted_value),
        .o_depth_after   (o_depth_after),
        .o_run_last      (o_run_last)
    );

    // Tokens are taken only in the fetch step
    assign o_in_stall = !ctrl.take;

endmodule

// ===== sim/slr_expression_parse_engine_top_tb.sv =====
// Self-checking testbench of the SLR expression parse engine: tokens in, actions checked.
`timescale 1ns / 100ps

module slr_expression_parse_engine_top_tb;

    // Terminal codes
    typedef enum logic [2:0] {
        TKN_NUM, TKN_PLUS, TKN_MINUS, TKN_STAR, TKN_SLASH, TKN_LPAR, TKN_RPAR, TKN_END
    } t_token;

    // Class held in the upper nibble of a table action
    typedef enum logic [3:0] {
        ACT_ERROR  = 4'd0,
        ACT_SHIFT  = 4'd1,
        ACT_REDUCE = 4'd2,
        ACT_ACCEPT = 4'd3
    } t_act_class;

    // Receiver stall behavior, switched at the end of each randomly sized phase
    typedef enum logic [1:0] {STL_NONE, STL_COIN, STL_HEAVY, STL_BLOCKS} t_stall_mode;

    typedef struct packed {
        slr_pkg::t_akind kind;
        logic [2:0]      prod;
        logic [3:0]      state;
        logic [31:0]     value;
        logic [5:0]      depth;
        logic            last;
    } t_parse_action;

    localparam int STACK_SIZE     = 32;
    localparam int REDUCE_LIMIT   = 4;
    localparam int RANDOM_ITEMS   = 180;
    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = 20;

    // SLR action table, state by terminal: class in the upper nibble, target below
    localparam logic [7:0] PARSE_ACTION [16][8] = '{
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h00, 8'h16, 8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h30},
        '{8'h00, 8'h22, 8'h22, 8'h18, 8'h19, 8'h00, 8'h22, 8'h22},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h00, 8'h26, 8'h26, 8'h26, 8'h26, 8'h00, 8'h26, 8'h26},
        '{8'h00, 8'h25, 8'h25, 8'h25, 8'h25, 8'h00, 8'h25, 8'h25},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h14, 8'h00, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00},
        '{8'h00, 8'h16, 8'h17, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h00},
        '{8'h00, 8'h20, 8'h20, 8'h18, 8'h19, 8'h00, 8'h20, 8'h20},
        '{8'h00, 8'h21, 8'h21, 8'h18, 8'h19, 8'h00, 8'h21, 8'h21},
        '{8'h00, 8'h23, 8'h23, 8'h23, 8'h23, 8'h00, 8'h23, 8'h23},
        '{8'h00, 8'h24, 8'h24, 8'h24, 8'h24, 8'h00, 8'h24, 8'h24},
        '{8'h00, 8'h27, 8'h27, 8'h27, 8'h27, 8'h00, 8'h27, 8'h27}
    };

    // Goto on E, T, F; zero is no entry
    localparam logic [3:0] GOTO_NT [16][3] = '{
        '{4'd1, 4'd2, 4'd5}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd10, 4'd2, 4'd5},
        '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd11, 4'd5}, '{4'd0, 4'd12, 4'd5},
        '{4'd0, 4'd0, 4'd13}, '{4'd0, 4'd0, 4'd14}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}, '{4'd0, 4'd0, 4'd0}
    };

    // Nonterminal produced and symbols popped by each rule
    localparam int RULE_HEAD [8] = '{0, 0, 0, 1, 1, 1, 2, 2};
    localparam int RULE_SIZE [8] = '{3, 3, 1, 3, 3, 1, 1, 3};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_token_kind = 3'd0;
    logic [31:0] i_token_value = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_action_kind;
    logic [2:0]  o_production;
    logic [3:0]  o_new_state;
    logic [31:0] o_shifted_value;
    logic [5:0]  o_depth_after;
    logic        o_run_last;

    slr_expression_parse_engine_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_token_kind    (i_token_kind),
        .i_token_value   (i_token_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_action_kind   (o_action_kind),
        .o_production    (o_production),
        .o_new_state     (o_new_state),
        .o_shifted_value (o_shifted_value),
        .o_depth_after   (o_depth_after),
        .o_run_last      (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted parser state and pending actions
    logic [3:0]    model_stack [STACK_SIZE];
    int            parse_depth;
    t_parse_action expected_actions [$];

    int mismatch_count = 0;
    int result_count = 0;
    int tokens_sent = 0;
    int burst_left = 0;

    function automatic t_parse_action mk_action(slr_pkg::t_akind k, logic [2:0] p,
                                                logic [3:0] s, logic [31:0] v, int d);
        t_parse_action a;
        a.kind  = k;
        a.prod  = p;
        a.state = s;
        a.value = v;
        a.depth = 6'(d);
        a.last  = 1'b0;
        return a;
    endfunction

    // Back to a single entry holding state 0; the action that ended the run
    function automatic t_parse_action restart_parse(slr_pkg::t_akind k);
        for (int i = 0; i < STACK_SIZE; i++) model_stack[i] = 4'd0;
        parse_depth = 1;
        return mk_action(k, 3'd0, 4'd0, 32'd0, 1);
    endfunction

    // Reductions the token calls for, then its shift, accept or error
    function automatic void predict_token(logic [2:0] tok, logic [31:0] val);
        t_parse_action steps [5];
        logic [7:0]    act;
        logic [3:0]    g;
        int            rule;
        int            n;
        int            nred;
        bit            done;
        n = 0;
        nred = 0;
        done = 1'b0;
        while (!done) begin
            act = PARSE_ACTION[model_stack[parse_depth-1]][tok];
            if (act[7:4] == ACT_REDUCE && nred < REDUCE_LIMIT) begin
                rule = int'(act[2:0]);
                if (parse_depth <= RULE_SIZE[rule]) begin
                    steps[n] = restart_parse(slr_pkg::AK_SYNTAX);
                    n++;
                    done = 1'b1;
                end else begin
                    g = GOTO_NT[model_stack[parse_depth-RULE_SIZE[rule]-1]][RULE_HEAD[rule]];
                    if (g == 4'd0) begin
                        steps[n] = restart_parse(slr_pkg::AK_SYNTAX);
                        n++;
                        done = 1'b1;
                    end else begin
                        parse_depth = parse_depth - RULE_SIZE[rule];
                        model_stack[parse_depth] = g;
                        parse_depth++;
                        nred++;
                        steps[n] = mk_action(slr_pkg::AK_REDUCE, act[2:0], g, 32'd0,
                                             parse_depth);
                        n++;
                    end
                end
            end else if (act[7:4] == ACT_SHIFT) begin
                if (parse_depth >= STACK_SIZE) begin
                    steps[n] = restart_parse(slr_pkg::AK_OVERFLOW);
                    n++;
                end else begin
                    model_stack[parse_depth] = act[3:0];
                    parse_depth++;
                    steps[n] = mk_action(slr_pkg::AK_SHIFT, 3'd0, act[3:0],
                                         (tok == TKN_NUM) ? val : 32'd0, parse_depth);
                    n++;
                end
                done = 1'b1;
            end else if (act[7:4] == ACT_ACCEPT) begin
                steps[n] = restart_parse(slr_pkg::AK_ACCEPT);
                n++;
                done = 1'b1;
            end else begin
                steps[n] = restart_parse(slr_pkg::AK_SYNTAX);
                n++;
                done = 1'b1;
            end
        end
        steps[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_actions.push_back(steps[i]);
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel == 0) return 32'd0;
        if (sel == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH: %s", what);
    endtask

    // Send one item; valid stays up inside a burst, drops for a random gap (sometimes none) between bursts
    task automatic send_token(input logic [2:0] tok, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_token_kind  <= tok;
        i_token_value <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_token(tok, val);
        tokens_sent++;
    endtask

    // Expression with random shape, well-formed unless broken is set; a higher nest_bias raises the odds of '('
    task automatic send_expression(input int max_nest, input int operands,
                                   input int nest_bias, input bit broken);
        int         open;
        int         used;
        bit         want_operand;
        bit         finished;
        logic [2:0] tok;
        open = 0;
        used = 0;
        want_operand = 1'b1;
        finished = 1'b0;
        while (!finished) begin
            if (want_operand) begin
                if (open < max_nest && used < operands && $urandom_range(0, 3) < nest_bias) begin
                    tok = TKN_LPAR;
                    open++;
                end else begin
                    tok = TKN_NUM;
                    used++;
                    want_operand = 1'b0;
                end
            end else if (open > 0 && (used >= operands || $urandom_range(0, 2) == 0)) begin
                tok = TKN_RPAR;
                open--;
            end else if (used >= operands) begin
                tok = TKN_END;
                finished = 1'b1;
            end else begin
                tok = 3'($urandom_range(TKN_PLUS, TKN_SLASH));
                want_operand = 1'b1;
            end
            // damaged sequences swap in a random terminal now and then
            if (broken && $urandom_range(0, 9) == 0) tok = 3'($urandom_range(0, 7));
            send_token(tok, pick_value());
        end
    endtask

    task test_reset_state;
        send_token(TKN_END, 32'd0);
    endtask

    task test_single_number;
        send_token(TKN_NUM, 32'd0);
        send_token(TKN_END, 32'hFFFF_FFFF);
    endtask

    // n + n * n - ( n / n ) end
    task test_all_operators;
        send_token(TKN_NUM,   32'hFFFF_FFFF);
        send_token(TKN_PLUS,  32'h5555_5555);
        send_token(TKN_NUM,   32'hAAAA_AAAA);
        send_token(TKN_STAR,  32'd0);
        send_token(TKN_NUM,   32'h5555_5555);
        send_token(TKN_MINUS, 32'hFFFF_FFFF);
        send_token(TKN_LPAR,  32'hAAAA_AAAA);
        send_token(TKN_NUM,   32'h8000_0000);
        send_token(TKN_SLASH, 32'd1);
        send_token(TKN_NUM,   32'd1);
        send_token(TKN_RPAR,  32'h8000_0000);
        send_token(TKN_END,   32'd0);
    endtask

    // Empty table entries from the start state and deeper in
    task test_syntax_errors;
        send_token(TKN_PLUS,  32'hAAAA_AAAA);
        send_token(TKN_MINUS, 32'h5555_5555);
        send_token(TKN_STAR,  32'hFFFF_FFFF);
        send_token(TKN_SLASH, 32'd0);
        send_token(TKN_RPAR,  32'h0000_0001);
        send_token(TKN_LPAR,  32'h5555_5555);
        send_token(TKN_END,   32'hAAAA_AAAA);
        send_token(TKN_NUM,   32'h1234_5678);
        send_token(TKN_NUM,   32'h8765_4321);
    endtask

    // Shift onto a full stack, directly and after a chain of reductions
    task test_stack_overflow;
        repeat (STACK_SIZE - 1) send_token(TKN_LPAR, pick_value());
        send_token(TKN_NUM, 32'hFFFF_FFFF);
        repeat (STACK_SIZE - 2) send_token(TKN_LPAR, pick_value());
        send_token(TKN_NUM, 32'h8000_0001);
        send_token(TKN_RPAR, 32'd0);
    endtask

    task test_random_expressions;
        int start;
        int pick;
        start = tokens_sent;
        while (tokens_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                repeat ($urandom_range(1, 5)) send_token(3'($urandom_range(0, 7)), pick_value());
            end else if (pick < 4) begin
                send_expression($urandom_range(8, 14), $urandom_range(4, 16), 3, 1'b0);
            end else begin
                send_expression($urandom_range(0, 4), $urandom_range(1, 6), 1, pick < 7);
            end
        end
    endtask

    // Receiver stall pattern
    t_stall_mode stall_mode = STL_NONE;
    int          stall_phase_left = 0;
    int          stall_hold = 0;

    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode       <= t_stall_mode'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(20, 120);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_mode)
            STL_NONE:  i_out_stall <= 1'b0;
            STL_COIN:  i_out_stall <= ($urandom_range(0, 1) == 1);
            STL_HEAVY: i_out_stall <= ($urandom_range(0, 7) != 0);
            default: begin
                if (stall_hold == 0) begin
                    i_out_stall <= ~i_out_stall;
                    stall_hold  <= $urandom_range(0, 6);
                end else begin
                    stall_hold <= stall_hold - 1;
                end
            end
        endcase
    end

    // Compare each taken result with the oldest prediction
    t_parse_action want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_actions.size() == 0) begin
                report_mismatch($sformatf("result %0d not expected, kind %0d",
                                          result_count, o_action_kind));
            end else begin
                want = expected_actions.pop_front();
                if (o_action_kind !== want.kind)
                    report_mismatch($sformatf("result %0d action_kind %0d, want %0d",
                                              result_count, o_action_kind, want.kind));
                if (o_production !== want.prod)
                    report_mismatch($sformatf("result %0d production %0d, want %0d",
                                              result_count, o_production, want.prod));
                if (o_new_state !== want.state)
                    report_mismatch($sformatf("result %0d new_state %0d, want %0d",
                                              result_count, o_new_state, want.state));
                if (o_shifted_value !== want.value)
                    report_mismatch($sformatf("result %0d shifted_value %h, want %h",
                                              result_count, o_shifted_value, want.value));
                if (o_depth_after !== want.depth)
                    report_mismatch($sformatf("result %0d depth_after %0d, want %0d",
                                              result_count, o_depth_after, want.depth));
                if (o_run_last !== want.last)
                    report_mismatch($sformatf("result %0d run_last %0b, want %0b",
                                              result_count, o_run_last, want.last));
            end
            result_count++;
        end
    end

    // Watchdog on cycles with no item moving on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("slr_expression_parse_engine_top_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < STACK_SIZE; i++) model_stack[i] = 4'd0;
        parse_depth = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state;
        test_single_number;
        test_all_operators;
        test_syntax_errors;
        test_stack_overflow;
        test_random_expressions;

        i_in_valid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("slr_expression_parse_engine_top_tb OK");
        end else begin
            $display("slr_expression_parse_engine_top_tb NOT OK");
        end
        $finish;
    end

endmodule
